// ===== hw/rtl/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int          MaxResults = 4;   // results one item can cause
    localparam logic [7:0]  C_PAD      = 8'h3D;   // '='
    localparam logic [7:0]  C_PLUS     = 8'h2B;   // '+'
    localparam logic [7:0]  C_SLASH    = 8'h2F;   // '/'
    localparam logic        C_REG_MODE = 1'b0;    // register index of decode_mode
    localparam int          AddrW      = 3;       // paddr width

    // group state carried from item to item
    typedef struct packed {
        logic [1:0] pos;    // items taken in current group
        logic [5:0] held;   // leftover bits, right aligned
        logic       pad;    // '=' seen (decode only)
    } t_codec_state;

    // results caused by one item
    typedef struct packed {
        logic [2:0]                 num;
        logic [MaxResults-1:0][7:0] value;
        logic [MaxResults-1:0]      has_data;
        logic [MaxResults-1:0]      last;
    } t_burst;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h47 + w;            // 'a' - 26
        end else if (v < 6'd62) begin
            return w - 8'd4;             // '0' - 52
        end else if (v == 6'd62) begin
            return C_PLUS;
        end else begin
            return C_SLASH;
        end
    endfunction

    // anything outside the alphabet maps to 63
    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'd4;
        end else if (c == C_PLUS) begin
            d = 8'd62;
        end else begin
            d = 8'd63;
        end
        return d[5:0];
    endfunction

endpackage

// ===== hw/rtl/b64c_apb.sv =====
// ----------------------------------------------------------------------------
// b64c_apb
// APB register port: holds decode_mode, flags a write so group state clears.
// ----------------------------------------------------------------------------
module b64c_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [b64c_pkg::AddrW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output logic [31:0]                o_prdata,
    output logic                       o_pready,
    output logic                       o_decode_mode,
    output logic                       o_mode_write
);
    import b64c_pkg::*;

    logic r_decode_mode;
    logic wr_en;
    logic hit;

    assign o_pready = 1'b1;
    assign hit      = (i_paddr[2] == C_REG_MODE);
    assign wr_en    = i_psel & i_penable & i_pwrite & hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
        end else if (wr_en) begin
            r_decode_mode <= i_pwdata[0];
        end
    end

    assign o_prdata      = hit ? {31'd0, r_decode_mode} : 32'd0;
    assign o_decode_mode = r_decode_mode;
    assign o_mode_write  = wr_en;

endmodule

// ===== hw/rtl/b64c_step.sv =====
// ----------------------------------------------------------------------------
// b64c_step
// Per-item combinational step: result burst and next group state.
// ----------------------------------------------------------------------------
module b64c_step (
    input  logic                    i_decode_mode,
    input  logic [7:0]              i_value,
    input  logic                    i_last,
    input  b64c_pkg::t_codec_state  i_state,
    output b64c_pkg::t_codec_state  o_state,
    output b64c_pkg::t_burst        o_burst
);
    import b64c_pkg::*;

    always_comb begin
        t_burst       b;
        t_codec_state s;
        logic [2:0]   n;
        logic [5:0]   v;
        b = '0;
        s = i_state;
        n = 3'd0;
        v = char_to_sextet(i_value);

        if (!i_decode_mode) begin
            case (s.pos)
                2'd0: begin
                    b.value[n[1:0]] = sextet_to_char(i_value[7:2]);
                    b.has_data[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                    s.held = {4'd0, i_value[1:0]};
                    s.pos  = 2'd1;
                end
                2'd1: begin
                    b.value[n[1:0]] = sextet_to_char({s.held[1:0], i_value[7:4]});
                    b.has_data[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                    s.held = {2'd0, i_value[3:0]};
                    s.pos  = 2'd2;
                end
                default: begin
                    b.value[n[1:0]] = sextet_to_char({s.held[3:0], i_value[7:6]});
                    b.has_data[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                    b.value[n[1:0]] = sextet_to_char(i_value[5:0]);
                    b.has_data[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                    s.held = 6'd0;
                    s.pos  = 2'd0;
                end
            endcase
            // flush partial group with padding
            if (i_last && s.pos == 2'd1) begin
                b.value[n[1:0]] = sextet_to_char({s.held[1:0], 4'd0});
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
                b.value[n[1:0]] = C_PAD;
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
                b.value[n[1:0]] = C_PAD;
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
            end else if (i_last && s.pos == 2'd2) begin
                b.value[n[1:0]] = sextet_to_char({s.held[3:0], 2'd0});
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
                b.value[n[1:0]] = C_PAD;
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
            end
        end else begin
            if (!s.pad) begin
                if (i_value == C_PAD) begin
                    s.pad = 1'b1;
                end else begin
                    case (s.pos)
                        2'd0: begin
                            s.held = v;
                            s.pos  = 2'd1;
                        end
                        2'd1: begin
                            b.value[n[1:0]] = {s.held, v[5:4]};
                            b.has_data[n[1:0]] = 1'b1;
                            n = n + 3'd1;
                            s.held = {2'd0, v[3:0]};
                            s.pos  = 2'd2;
                        end
                        2'd2: begin
                            b.value[n[1:0]] = {s.held[3:0], v[5:2]};
                            b.has_data[n[1:0]] = 1'b1;
                            n = n + 3'd1;
                            s.held = {4'd0, v[1:0]};
                            s.pos  = 2'd3;
                        end
                        default: begin
                            b.value[n[1:0]] = {s.held[1:0], v};
                            b.has_data[n[1:0]] = 1'b1;
                            n = n + 3'd1;
                            s.held = 6'd0;
                            s.pos  = 2'd0;
                        end
                    endcase
                end
            end
            // single leftover character still gives a byte
            if (i_last && s.pos == 2'd1) begin
                b.value[n[1:0]] = {s.held, 2'd0};
                b.has_data[n[1:0]] = 1'b1;
                n = n + 3'd1;
            end
        end

        if (i_last) begin
            if (n == 3'd0) begin
                // bare end marker
                b.value[0]    = 8'd0;
                b.has_data[0] = 1'b0;
                n = 3'd1;
            end
            b.last[n[1:0] - 2'd1] = 1'b1;
            s = '0;
        end

        b.num   = n;
        o_burst = b;
        o_state = s;
    end

endmodule

// ===== hw/rtl/b64c_burst.sv =====
// ----------------------------------------------------------------------------
// b64c_burst
// Result register: holds one item's burst and hands it out one per cycle while i_m_tready is high.
// ----------------------------------------------------------------------------
module b64c_burst (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  b64c_pkg::t_burst  i_burst,
    input  logic              i_m_tready,
    output logic              o_can_load,
    output logic              o_m_tvalid,
    output logic [7:0]        o_value,
    output logic              o_has_data,
    output logic              o_last
);
    import b64c_pkg::*;

    logic [MaxResults-1:0][7:0] r_value;
    logic [MaxResults-1:0]      r_has_data;
    logic [MaxResults-1:0]      r_lastv;
    logic [2:0]                 r_left;
    logic [1:0]                 r_rd;
    logic                       pop;

    assign o_m_tvalid = (r_left != 3'd0);
    assign pop        = o_m_tvalid & i_m_tready;
    // room when empty or once the last held result leaves this cycle
    assign o_can_load = (r_left == 3'd0) || (r_left == 3'd1 && i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_rd   <= 2'd0;
        end else if (i_load) begin
            r_left <= i_burst.num;
            r_rd   <= 2'd0;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value    <= i_burst.value;
            r_has_data <= i_burst.has_data;
            r_lastv    <= i_burst.last;
        end
    end

    assign o_value    = r_value[r_rd];
    assign o_has_data = r_has_data[r_rd];
    assign o_last     = r_lastv[r_rd];

endmodule

// ===== hw/rtl/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard alphabet, '=' padding.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------------
//  s (in)    slave      i_s_tvalid/o_s_tready   tdata[7:0]=in_value, tlast=in_last
//  m (out)   master     o_m_tvalid/i_m_tready   tdata[7:0]=out_value,
//                                               tuser[0]=out_has_data,
//                                               tlast=out_last
//  cfg       APB        psel/penable, pready=1  addr 0: decode_mode (bit 0)
//
//  Each item is processed in the cycle it is accepted; its 0..4 results land in
//  the result register and leave one per cycle while i_m_tready is high. The
//  next item is taken once the register is empty or in the cycle the last held
//  result leaves, so an item with more results holds the input back longer.
//  The single output port sets the pace of the input.
//  Reset is synchronous, active low; it clears mode, group state and the
//  result count. Output stalls hold the burst and back-pressure the input.
//  A write to decode_mode clears the group state.
//
module base64_stream_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] in_value
    input  logic                       i_s_tlast,
    // output stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [7:0] out_value
    output logic [0:0]                 o_m_tuser,   // [0] out_has_data
    output logic                       o_m_tlast,
    // configuration
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [b64c_pkg::AddrW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output logic [31:0]                o_prdata,
    output logic                       o_pready
);
    import b64c_pkg::*;

    logic          decode_mode;
    logic          mode_write;
    logic          accept;
    logic          can_load;
    logic          has_data;
    t_codec_state  r_state;
    t_codec_state  n_state;
    t_burst        burst;

    b64c_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready),
        .o_decode_mode (decode_mode),
        .o_mode_write  (mode_write)
    );

    // the step logic works straight off the accepted item and group state
    b64c_step u_step (
        .i_decode_mode (decode_mode),
        .i_value       (i_s_tdata),
        .i_last        (i_s_tlast),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_burst       (burst)
    );

    assign o_s_tready = can_load;
    assign accept     = i_s_tvalid & can_load;

    // group state: cleared by reset and by any mode write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || mode_write) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    b64c_burst u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .i_m_tready (i_m_tready),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .o_value    (o_m_tdata),
        .o_has_data (has_data),
        .o_last     (o_m_tlast)
    );

    assign o_m_tuser = has_data;

endmodule
